/* design/topkt_pkg.sv */
// Shared types and constants for the topic key table.
// Used by topkt_store, topkt_match and topic_key_table; depends on nothing.
package topkt_pkg;

  localparam logic [2:0] OP_LOOKUP       = 3'd0;
  localparam logic [2:0] OP_SET_KEY      = 3'd1;
  localparam logic [2:0] OP_REMOVE       = 3'd2;
  localparam logic [2:0] OP_RESET        = 3'd3;
  localparam logic [2:0] OP_SET_ID_KEY   = 3'd4;
  localparam logic [2:0] OP_SET_ID_ENTRY = 3'd5;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  localparam int HASH_PORT_BITS = 128;
  localparam int KEY_PORT_BITS  = 256;

  // Write enables for the two halves of a table entry.
  typedef struct packed {
    logic hash_we;
    logic key_we;
  } wr_en_t;

  // Outcome of comparing one stored hash against the target.
  typedef struct packed {
    logic hit;
    logic last;
  } match_t;

endpackage

/* design/topic_key_table.sv */
// Topic key table top level: sequencer, request/result registers, entry count.
// Instantiates topkt_store and topkt_match; depends on topkt_pkg.
//
// Usage: a request transaction (req_valid/req_ready) carries an operation, a
// topic hash and a key. Each request yields exactly one result transaction
// (rsp_valid/rsp_ready) with status, match_index, the looked-up key and the
// number of used entries. req_ready is high only while the sequencer is idle,
// so one request is worked on at a time.
// Searches walk the used entries one per cycle through the shared compare unit;
// a remove then moves each later entry up one slot per cycle over the single
// memory write port. The sequencer returns to idle as the result is registered
// and can then take the next request. The result sits in an output register:
// a new request is accepted while an earlier result still waits, and the
// sequencer only holds in its final state if a second result is ready before
// the receiver has taken the first. Reset clears the entry count and the
// handshake state; entries beyond the count are never read, so the memories
// need no clearing pass after reset.
module topic_key_table #(
  parameter int MAX_ENTRIES = 64,
  parameter int HASH_BITS   = 128,
  parameter int KEY_BITS    = 256,
  localparam int CNT_W      = $clog2(MAX_ENTRIES + 1),
  localparam int IDX_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  logic [2:0]       operation,
  input  logic [63:0]      topic_hash_lo,
  input  logic [63:0]      topic_hash_hi,
  input  logic [63:0]      key_word0,
  input  logic [63:0]      key_word1,
  input  logic [63:0]      key_word2,
  input  logic [63:0]      key_word3,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output logic             status,
  output logic [CNT_W-1:0] match_index,
  output logic [63:0]      out_key_word0,
  output logic [63:0]      out_key_word1,
  output logic [63:0]      out_key_word2,
  output logic [63:0]      out_key_word3,
  output logic [CNT_W-1:0] used_count
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECODE = 3'd1;
  localparam logic [2:0] ST_SEARCH = 3'd2;
  localparam logic [2:0] ST_SHIFT  = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  localparam logic [CNT_W-1:0] NO_INDEX = CNT_W'(MAX_ENTRIES);

  logic [2:0]           state;
  logic [2:0]           op;
  logic [HASH_BITS-1:0] hash;
  logic [KEY_BITS-1:0]  key;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     scan_idx;
  logic                 cmp_vld;
  logic [IDX_W-1:0]     cmp_idx;
  logic                 res_status;
  logic [CNT_W-1:0]     res_index;
  logic [KEY_BITS-1:0]  res_key;

  logic [topkt_pkg::HASH_PORT_BITS-1:0] hash_in;
  logic [topkt_pkg::KEY_PORT_BITS-1:0]  key_in;
  logic [topkt_pkg::KEY_PORT_BITS-1:0]  key_out;

  topkt_pkg::wr_en_t    wr_en;
  logic [IDX_W-1:0]     waddr;
  logic [HASH_BITS-1:0] whash;
  logic [KEY_BITS-1:0]  wkey;
  logic                 re;
  logic [HASH_BITS-1:0] rd_hash;
  logic [KEY_BITS-1:0]  rd_key;
  topkt_pkg::match_t    m;
  logic                 miss;
  logic                 more;

  assign hash_in = {topic_hash_hi, topic_hash_lo};
  assign key_in  = {key_word3, key_word2, key_word1, key_word0};
  assign key_out = topkt_pkg::KEY_PORT_BITS'(res_key);

  assign req_ready = (state == ST_IDLE);

  // Another used entry remains to be read.
  assign more = (scan_idx < count);
  // The scan is over without a hit, also when the table is empty.
  assign miss = (m.last && !m.hit) || (!cmp_vld && !more);

  assign re    = ((state == ST_SEARCH) && more && !m.hit) || ((state == ST_SHIFT) && more);

  topkt_store #(
    .DEPTH     (MAX_ENTRIES),
    .HASH_BITS (HASH_BITS),
    .KEY_BITS  (KEY_BITS),
    .IDX_W     (IDX_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .waddr   (waddr),
    .whash   (whash),
    .wkey    (wkey),
    .re      (re),
    .raddr   (scan_idx[IDX_W-1:0]),
    .rd_hash (rd_hash),
    .rd_key  (rd_key)
  );

  topkt_match #(
    .HASH_BITS (HASH_BITS),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W)
  ) u_match (
    .rd_hash (rd_hash),
    .target  (hash),
    .cmp_vld (cmp_vld),
    .cmp_idx (cmp_idx),
    .count   (count),
    .result  (m)
  );

  // Memory write port.
  always_comb begin
    wr_en = '0;
    waddr = '0;
    whash = hash;
    wkey  = key;
    case (state)
      ST_DECODE: begin
        if (op == topkt_pkg::OP_SET_ID_KEY) begin
          wr_en.key_we = 1'b1;
        end else if (op == topkt_pkg::OP_SET_ID_ENTRY) begin
          wr_en.hash_we = 1'b1;
          wr_en.key_we  = 1'b1;
        end
      end
      ST_SEARCH: begin
        if (op == topkt_pkg::OP_SET_KEY) begin
          if (m.hit) begin
            wr_en.hash_we = 1'b1;
            wr_en.key_we  = 1'b1;
            waddr         = cmp_idx;
          end else if (miss && (count < NO_INDEX)) begin
            wr_en.hash_we = 1'b1;
            wr_en.key_we  = 1'b1;
            waddr         = count[IDX_W-1:0];
          end
        end
      end
      ST_SHIFT: begin
        // The entry read last cycle moves up by one slot.
        if (cmp_vld) begin
          wr_en.hash_we = 1'b1;
          wr_en.key_we  = 1'b1;
          waddr         = cmp_idx - IDX_W'(1);
          whash         = rd_hash;
          wkey          = rd_key;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      cmp_vld   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // In the final state the result register decides rsp_valid itself.
      if (rsp_valid && rsp_ready && (state != ST_FINISH)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_valid) begin
            op    <= operation;
            hash  <= hash_in[HASH_BITS-1:0];
            key   <= key_in[KEY_BITS-1:0];
            state <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          scan_idx   <= '0;
          cmp_vld    <= 1'b0;
          res_key    <= '0;
          res_status <= topkt_pkg::STATUS_FAIL;
          res_index  <= NO_INDEX;
          state      <= ST_FINISH;
          case (op) inside
            topkt_pkg::OP_LOOKUP, topkt_pkg::OP_SET_KEY, topkt_pkg::OP_REMOVE: begin
              state <= ST_SEARCH;
            end
            topkt_pkg::OP_RESET: begin
              if (count != '0) begin
                count      <= CNT_W'(1);
                res_status <= topkt_pkg::STATUS_OK;
              end
            end
            topkt_pkg::OP_SET_ID_KEY: begin
              res_status <= topkt_pkg::STATUS_OK;
              res_index  <= '0;
            end
            topkt_pkg::OP_SET_ID_ENTRY: begin
              res_status <= topkt_pkg::STATUS_OK;
              res_index  <= '0;
              if (count == '0) begin
                count <= CNT_W'(1);
              end
            end
            default: begin
            end
          endcase
        end
        ST_SEARCH: begin
          if (m.hit) begin
            res_status <= topkt_pkg::STATUS_OK;
            res_index  <= CNT_W'(cmp_idx);
            cmp_vld    <= 1'b0;
            if (op == topkt_pkg::OP_LOOKUP) begin
              res_key <= rd_key;
            end
            // scan_idx already points just past the hit for the shift.
            state <= (op == topkt_pkg::OP_REMOVE) ? ST_SHIFT : ST_FINISH;
          end else if (miss) begin
            cmp_vld <= 1'b0;
            if ((op == topkt_pkg::OP_SET_KEY) && (count < NO_INDEX)) begin
              res_status <= topkt_pkg::STATUS_OK;
              res_index  <= count;
              count      <= count + CNT_W'(1);
            end
            state <= ST_FINISH;
          end else begin
            cmp_vld  <= 1'b1;
            cmp_idx  <= scan_idx[IDX_W-1:0];
            scan_idx <= scan_idx + CNT_W'(1);
          end
        end
        ST_SHIFT: begin
          if (more) begin
            cmp_vld  <= 1'b1;
            cmp_idx  <= scan_idx[IDX_W-1:0];
            scan_idx <= scan_idx + CNT_W'(1);
          end else begin
            cmp_vld <= 1'b0;
            if (!cmp_vld) begin
              count <= count - CNT_W'(1);
              state <= ST_FINISH;
            end
          end
        end
        ST_FINISH: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid     <= 1'b1;
            status        <= res_status;
            match_index   <= res_index;
            out_key_word0 <= key_out[63:0];
            out_key_word1 <= key_out[127:64];
            out_key_word2 <= key_out[191:128];
            out_key_word3 <= key_out[255:192];
            used_count    <= count;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* design/topkt_store.sv */
// Entry storage for the topic key table: hash and key memories.
// One write port with separate hash/key enables, one registered read port.
// Depends on topkt_pkg.
module topkt_store #(
  parameter int DEPTH     = 64,
  parameter int HASH_BITS = 128,
  parameter int KEY_BITS  = 256,
  parameter int IDX_W     = 6
) (
  input  logic                   clk,
  input  topkt_pkg::wr_en_t      wr_en,
  input  logic [IDX_W-1:0]       waddr,
  input  logic [HASH_BITS-1:0]   whash,
  input  logic [KEY_BITS-1:0]    wkey,
  input  logic                   re,
  input  logic [IDX_W-1:0]       raddr,
  output logic [HASH_BITS-1:0]   rd_hash,
  output logic [KEY_BITS-1:0]    rd_key
);

  logic [HASH_BITS-1:0] hash_mem [DEPTH];
  logic [KEY_BITS-1:0]  key_mem  [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en.hash_we) begin
      hash_mem[waddr] <= whash;
    end
    if (wr_en.key_we) begin
      key_mem[waddr] <= wkey;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_hash <= hash_mem[raddr];
      rd_key  <= key_mem[raddr];
    end
  end

endmodule

/* design/topkt_match.sv */
// Shared hash compare unit for the topic key table scan.
// Compares the entry just read against the target and flags the last used entry.
// Depends on topkt_pkg.
module topkt_match #(
  parameter int HASH_BITS = 128,
  parameter int IDX_W     = 6,
  parameter int CNT_W     = 7
) (
  input  logic [HASH_BITS-1:0] rd_hash,
  input  logic [HASH_BITS-1:0] target,
  input  logic                 cmp_vld,
  input  logic [IDX_W-1:0]     cmp_idx,
  input  logic [CNT_W-1:0]     count,
  output topkt_pkg::match_t    result
);

  always_comb begin
    result.hit  = cmp_vld && (rd_hash == target);
    result.last = cmp_vld && ((CNT_W'(cmp_idx) + CNT_W'(1)) == count);
  end

endmodule
